// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by indexed_list_engine. Each macro clocks on
// clk_i and is disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge out of reset.
`define ILE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// An antecedent in one cycle implies a consequent in the same cycle.
`define ILE_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// An antecedent in one cycle implies a consequent in the next cycle.
`define ILE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/ile_pkg.sv =====
// ----------------------------------------------------------------------------
// ile_pkg
// Types and codes shared by the list engine cells and the top level.
// ----------------------------------------------------------------------------
package ile_pkg;

  typedef logic signed [31:0] value_t;

  // Request codes.
  localparam logic [2:0] OP_READ      = 3'd0;
  localparam logic [2:0] OP_INS_FRONT = 3'd1;
  localparam logic [2:0] OP_INS_BACK  = 3'd2;
  localparam logic [2:0] OP_INS_AT    = 3'd3;
  localparam logic [2:0] OP_DELETE    = 3'd4;

  // Result status codes.
  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_OOR  = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  // Cells per first-level group of the read reduction.
  localparam int GROUP_SIZE = 32;

  // Command broadcast to every cell of the chain.
  typedef struct packed {
    logic rd;   // read the entry at the position
    logic ins;  // insert before the position, later cells take their left
    logic del;  // delete at the position, later cells take their right
  } cell_cmd_t;

endpackage

// ===== src/indexed_list_engine.sv =====
// ----------------------------------------------------------------------------
// indexed_list_engine
// Ordered list of up to CAPACITY signed values held in a chain of cells.
// ----------------------------------------------------------------------------
// Usage:
//   The request channel (in_valid_i/in_ready_o) carries op_i, position_i and
//   value_in_i. Every request produces exactly one transaction on the result
//   channel (out_valid_o/out_ready_i) with status_o, read_value_o and
//   entry_count_o, in request order.
//   Inserts and deletes shift the whole chain in the cycle the request is
//   accepted: every cell compares its own index with the position and loads,
//   takes a neighbor, or holds. A read is an AND-OR reduction over the cells,
//   registered per group of 32 cells, then combined into the output register.
//   The result is registered in the reduction stage, then in the output register.
//   Throughput: one request per cycle; the two-stage pipe of reduction stage and
//   output register keeps moving as long as the receiver takes results.
//   When the receiver stalls, one result waits in the output register and
//   one in the reduction stage; then in_ready_o drops until the stall ends.
//   Reset clears the entry count and both pipeline stages. Cell contents are
//   not reset; only positions below the count are ever read.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module indexed_list_engine #(
  parameter int CAPACITY = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [2:0]          op_i,
  input  logic [6:0]          position_i,
  input  logic signed [31:0]  value_in_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [1:0]          status_o,
  output logic signed [31:0]  read_value_o,
  output logic [6:0]          entry_count_o
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int W  = (CW > 7) ? CW : 7;
  localparam int NG = (CAPACITY + ile_pkg::GROUP_SIZE - 1) / ile_pkg::GROUP_SIZE;
  localparam logic [CW-1:0] CapC = CW'(CAPACITY);

  logic [CW-1:0]       count_q, count_d;
  logic                in_acc_w;
  logic [W-1:0]        pos_w, cnt_w;
  logic                full_w;
  ile_pkg::cell_cmd_t  cmd_w;
  logic [CW-1:0]       cell_pos_w;
  logic [1:0]          status_w;

  ile_pkg::value_t     entry_w [CAPACITY];
  ile_pkg::value_t     rd_w    [CAPACITY];
  ile_pkg::value_t     part_d  [NG];
  ile_pkg::value_t     part_q  [NG];

  logic                s1_valid_q;
  logic [1:0]          s1_status_q;
  logic [6:0]          s1_count_q;
  logic                s1_move_w;
  ile_pkg::value_t     rd_sum_w;

  logic                out_valid_q;
  logic [1:0]          out_status_q;
  ile_pkg::value_t     out_read_q;
  logic [6:0]          out_count_q;

  assign s1_move_w  = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_move_w;
  assign in_acc_w   = in_valid_i && in_ready_o;

  assign pos_w  = W'(position_i);
  assign cnt_w  = W'(count_q);
  assign full_w = (count_q == CapC);

  // Request decode: status and the command broadcast to the chain.
  always_comb begin
    cmd_w      = '0;
    cell_pos_w = CW'(pos_w);
    status_w   = ile_pkg::ST_DONE;
    unique case (op_i)
      ile_pkg::OP_READ: begin
        if (pos_w >= cnt_w) status_w = ile_pkg::ST_OOR;
        else                cmd_w.rd = in_acc_w;
      end
      ile_pkg::OP_INS_FRONT: begin
        cell_pos_w = '0;
        if (full_w) status_w  = ile_pkg::ST_FULL;
        else        cmd_w.ins = in_acc_w;
      end
      ile_pkg::OP_INS_BACK: begin
        cell_pos_w = count_q;
        if (full_w) status_w  = ile_pkg::ST_FULL;
        else        cmd_w.ins = in_acc_w;
      end
      ile_pkg::OP_INS_AT: begin
        if (pos_w > cnt_w) status_w  = ile_pkg::ST_OOR;
        else if (full_w)   status_w  = ile_pkg::ST_FULL;
        else               cmd_w.ins = in_acc_w;
      end
      ile_pkg::OP_DELETE: begin
        if (pos_w >= cnt_w) status_w  = ile_pkg::ST_OOR;
        else                cmd_w.del = in_acc_w;
      end
      default: begin
        status_w = ile_pkg::ST_OOR;
      end
    endcase
  end

  always_comb begin
    count_d = count_q;
    if (cmd_w.ins) begin
      count_d = count_q + CW'(1);
    end else if (cmd_w.del) begin
      count_d = count_q - CW'(1);
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    ile_pkg::value_t left_w, right_w;
    if (i == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = entry_w[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_w = entry_w[i];
    end else begin : g_mid_r
      assign right_w = entry_w[i+1];
    end
    ile_cell #(
      .IDX (i),
      .CW  (CW)
    ) u_cell (
      .clk_i   (clk_i),
      .cmd_i   (cmd_w),
      .pos_i   (cell_pos_w),
      .value_i (value_in_i),
      .left_i  (left_w),
      .right_i (right_w),
      .entry_o (entry_w[i]),
      .rd_o    (rd_w[i])
    );
  end

  // First level of the read reduction: OR of each group of cells.
  for (genvar g = 0; g < NG; g++) begin : g_group
    always_comb begin
      part_d[g] = '0;
      for (int j = 0; j < ile_pkg::GROUP_SIZE; j++) begin
        if (g * ile_pkg::GROUP_SIZE + j < CAPACITY) begin
          part_d[g] = part_d[g] | rd_w[g * ile_pkg::GROUP_SIZE + j];
        end
      end
    end
    always_ff @(posedge clk_i) begin
      if (in_acc_w) begin
        part_q[g] <= part_d[g];
      end
    end
  end

  always_comb begin
    rd_sum_w = '0;
    for (int g = 0; g < NG; g++) begin
      rd_sum_w = rd_sum_w | part_q[g];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (in_acc_w) begin
        s1_valid_q <= 1'b1;
      end else if (s1_move_w) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_move_w) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc_w) begin
      s1_status_q <= status_w;
      s1_count_q  <= W'(count_d) >> 0 == '0 ? 7'd0 : 7'(W'(count_d));
    end
    if (s1_move_w) begin
      out_status_q <= s1_status_q;
      out_read_q   <= rd_sum_w;
      out_count_q  <= s1_count_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign read_value_o  = out_read_q;
  assign entry_count_o = out_count_q;

  `ILE_ASSERT(a_count_bound, count_q <= CapC, "entry count exceeds capacity")
  `ILE_ASSERT_NEXT(a_ins_count, cmd_w.ins, count_q == $past(count_q) + CW'(1),
                   "insert did not advance the entry count")
  `ILE_ASSERT_NEXT(a_s1_hold, s1_valid_q && !s1_move_w, s1_valid_q,
                   "stalled reduction stage lost its result")
  `ILE_ASSERT_IMPL(a_rd_zero, out_valid_q && out_status_q != ile_pkg::ST_DONE,
                   out_read_q == '0, "failed request carries a nonzero read value")

endmodule

// ===== src/ile_cell.sv =====
// ----------------------------------------------------------------------------
// ile_cell
// One list slot. Holds a single entry and, on an insert or delete, loads the
// new value or takes the entry of its left or right neighbor.
// ----------------------------------------------------------------------------
module ile_cell #(
  parameter int IDX = 0,
  parameter int CW  = 7
) (
  input  logic                  clk_i,
  input  ile_pkg::cell_cmd_t    cmd_i,
  input  logic [CW-1:0]         pos_i,
  input  ile_pkg::value_t       value_i,
  input  ile_pkg::value_t       left_i,
  input  ile_pkg::value_t       right_i,
  output ile_pkg::value_t       entry_o,
  output ile_pkg::value_t       rd_o
);

  localparam logic [CW-1:0] IdxC = CW'(IDX);

  ile_pkg::value_t entry_q, entry_d;
  logic            at_w, after_w;

  assign at_w    = (IdxC == pos_i);
  assign after_w = (IdxC > pos_i);

  always_comb begin
    entry_d = entry_q;
    if (cmd_i.ins) begin
      if (at_w) begin
        entry_d = value_i;
      end else if (after_w) begin
        entry_d = left_i;
      end
    end else if (cmd_i.del && (at_w || after_w)) begin
      entry_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;
  // Only the addressed cell drives its entry onto the read reduction.
  assign rd_o    = (cmd_i.rd && at_w) ? entry_q : '0;

endmodule

// ===== tb/indexed_list_engine_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// indexed_list_engine_test
// Drives the list engine with a short table of directed requests and then
// long random runs that fill the list, drain it and churn it. Every result is
// checked field by field against a typed row's expectation or a behavioral list
// model in the testbench, while both handshake sides idle and stall at random.
// ----------------------------------------------------------------------------
module indexed_list_engine_test;

  localparam int CLK_PERIOD   = 10;
  localparam int LIST_DEPTH   = 64;
  localparam int PIPE_LATENCY = 2;
  localparam int DRAIN_CYCLES = 4 * PIPE_LATENCY;
  localparam int RANDOM_ITEMS = 1425;
  localparam int PAUSE_EVERY  = 500;
  localparam int CYCLE_LIMIT  = 400000;

  // Request codes that the block treats as unused.
  localparam logic [2:0] OP_RSVD5 = 3'd5;
  localparam logic [2:0] OP_RSVD6 = 3'd6;
  localparam logic [2:0] OP_RSVD7 = 3'd7;

  typedef struct packed {
    logic [1:0]       status;
    ile_pkg::value_t  read_value;
    logic [6:0]       entry_count;
  } list_result_t;

  typedef struct packed {
    logic [2:0]       op;
    logic [6:0]       pos;
    ile_pkg::value_t  val;
    logic             typed;
    list_result_t     want;
  } stim_row_t;

  typedef enum int {TIDE_FILL, TIDE_DRAIN, TIDE_CHURN} tide_e;
  typedef enum int {SINK_STEADY, SINK_RANDOM, SINK_PATTERN, SINK_HOLD} sink_mode_e;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             in_valid_i = 1'b0;
  logic             in_ready_o;
  logic [2:0]       op_i = ile_pkg::OP_READ;
  logic [6:0]       position_i = '0;
  ile_pkg::value_t  value_in_i = '0;
  logic             out_valid_o;
  logic             out_ready_i = 1'b0;
  logic [1:0]       status_o;
  ile_pkg::value_t  read_value_o;
  logic [6:0]       entry_count_o;

  // Travels with the request so the checker knows when a row carries its
  // own hand-written expectation.
  logic          row_typed = 1'b0;
  list_result_t  row_expect = '0;

  // Behavioral copy of the list.
  ile_pkg::value_t  list_mem [LIST_DEPTH];
  int unsigned      list_count = 0;

  list_result_t pending_results [$];
  int unsigned  mismatch_count = 0;
  int unsigned  checked_count = 0;
  int unsigned  status_tally [3] = '{0, 0, 0};
  int unsigned  peak_count = 0;
  int unsigned  cycle_count = 0;

  localparam int DIRECTED_ROWS = 24;
  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    '{ile_pkg::OP_READ,      7'd0,   32'sd0,         1'b1, '{ile_pkg::ST_OOR,  32'sd0, 7'd0}},
    '{ile_pkg::OP_DELETE,    7'd0,   32'sd0,         1'b1, '{ile_pkg::ST_OOR,  32'sd0, 7'd0}},
    '{ile_pkg::OP_INS_AT,    7'd1,   32'sd5,         1'b1, '{ile_pkg::ST_OOR,  32'sd0, 7'd0}},
    '{ile_pkg::OP_INS_AT,    7'd0,   32'sh7FFF_FFFF, 1'b1, '{ile_pkg::ST_DONE, 32'sd0, 7'd1}},
    '{ile_pkg::OP_INS_FRONT, 7'd0,   32'sh8000_0000, 1'b1, '{ile_pkg::ST_DONE, 32'sd0, 7'd2}},
    '{ile_pkg::OP_INS_BACK,  7'd127, 32'shFFFF_FFFF, 1'b1, '{ile_pkg::ST_DONE, 32'sd0, 7'd3}},
    '{ile_pkg::OP_READ,      7'd0,   32'sd0,         1'b0, '0},
    '{ile_pkg::OP_READ,      7'd1,   32'sd0,         1'b0, '0},
    '{ile_pkg::OP_READ,      7'd2,   32'sd0,         1'b0, '0},
    '{ile_pkg::OP_READ,      7'd3,   32'sd0,         1'b1, '{ile_pkg::ST_OOR,  32'sd0, 7'd3}},
    '{ile_pkg::OP_READ,      7'd127, 32'sd0,         1'b1, '{ile_pkg::ST_OOR,  32'sd0, 7'd3}},
    '{ile_pkg::OP_INS_AT,    7'd3,   32'sd0,         1'b0, '0},
    '{ile_pkg::OP_INS_AT,    7'd1,   32'sh5A5A_5A5A, 1'b0, '0},
    '{ile_pkg::OP_INS_AT,    7'd127, 32'shA5A5_A5A5, 1'b1, '{ile_pkg::ST_OOR,  32'sd0, 7'd5}},
    '{ile_pkg::OP_READ,      7'd4,   32'sd0,         1'b0, '0},
    '{ile_pkg::OP_DELETE,    7'd0,   32'sd0,         1'b0, '0},
    '{ile_pkg::OP_DELETE,    7'd3,   32'sd0,         1'b0, '0},
    '{ile_pkg::OP_DELETE,    7'd64,  32'sd0,         1'b1, '{ile_pkg::ST_OOR,  32'sd0, 7'd3}},
    '{OP_RSVD5,              7'd0,   32'sd7,         1'b1, '{ile_pkg::ST_OOR,  32'sd0, 7'd3}},
    '{OP_RSVD6,              7'd1,   32'sd0,         1'b1, '{ile_pkg::ST_OOR,  32'sd0, 7'd3}},
    '{OP_RSVD7,              7'd127, 32'shFFFF_FFFF, 1'b1, '{ile_pkg::ST_OOR,  32'sd0, 7'd3}},
    '{ile_pkg::OP_READ,      7'd1,   32'sd0,         1'b0, '0},
    '{ile_pkg::OP_DELETE,    7'd1,   32'sd0,         1'b0, '0},
    '{ile_pkg::OP_INS_FRONT, 7'd64,  32'sd1,         1'b0, '0}
  };

  indexed_list_engine #(
    .CAPACITY(LIST_DEPTH)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .op_i         (op_i),
    .position_i   (position_i),
    .value_in_i   (value_in_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .status_o     (status_o),
    .read_value_o (read_value_o),
    .entry_count_o(entry_count_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  function automatic void list_insert(int unsigned at, ile_pkg::value_t val);
    int unsigned i;
    for (i = list_count; i > at; i--) list_mem[i] = list_mem[i - 1];
    list_mem[at] = val;
    list_count++;
  endfunction

  // Applies one request to the list copy and returns the result it produces.
  function automatic list_result_t list_apply(logic [2:0] op, logic [6:0] pos,
                                              ile_pkg::value_t val);
    list_result_t res;
    int unsigned  p;
    int unsigned  i;
    res = '0;
    res.status = ile_pkg::ST_DONE;
    p = 32'(pos);
    case (op)
      ile_pkg::OP_READ: begin
        if (p >= list_count) res.status = ile_pkg::ST_OOR;
        else res.read_value = list_mem[p];
      end
      ile_pkg::OP_INS_FRONT: begin
        if (list_count >= LIST_DEPTH) res.status = ile_pkg::ST_FULL;
        else list_insert(0, val);
      end
      ile_pkg::OP_INS_BACK: begin
        if (list_count >= LIST_DEPTH) res.status = ile_pkg::ST_FULL;
        else list_insert(list_count, val);
      end
      ile_pkg::OP_INS_AT: begin
        // A bad position wins over a full list.
        if (p > list_count) res.status = ile_pkg::ST_OOR;
        else if (list_count >= LIST_DEPTH) res.status = ile_pkg::ST_FULL;
        else list_insert(p, val);
      end
      ile_pkg::OP_DELETE: begin
        if (p >= list_count) begin
          res.status = ile_pkg::ST_OOR;
        end else begin
          for (i = p; i + 1 < list_count; i++) list_mem[i] = list_mem[i + 1];
          list_count--;
        end
      end
      default: res.status = ile_pkg::ST_OOR;
    endcase
    res.entry_count = list_count[6:0];
    return res;
  endfunction

  task automatic report_field(string field, int want, int got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected %0d (0x%08h), actual %0d (0x%08h)",
               $time, field, want, want, got, got);
      mismatch_count++;
    end
  endtask

  // Holds a request on the bus until the block takes it.
  task automatic offer(logic [2:0] op, logic [6:0] pos, ile_pkg::value_t val,
                       logic typed, list_result_t want);
    in_valid_i <= 1'b1;
    op_i       <= op;
    position_i <= pos;
    value_in_i <= val;
    row_typed  <= typed;
    row_expect <= want;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic idle(int unsigned cycles);
    in_valid_i <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // Prediction happens before the result check so that a request and a result
  // in the same cycle are always handled in order.
  always @(posedge clk_i) begin : result_check
    list_result_t predicted;
    list_result_t want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        predicted = list_apply(op_i, position_i, value_in_i);
        pending_results.push_back(row_typed ? row_expect : predicted);
      end
      if (out_valid_o && out_ready_i) begin
        if (pending_results.size() == 0) begin
          $display("%0t ns: result with none expected, actual status %0d value %0d count %0d",
                   $time, status_o, read_value_o, entry_count_o);
          mismatch_count++;
        end else begin
          want = pending_results.pop_front();
          report_field("status", int'(want.status), int'(status_o));
          report_field("read_value", int'(want.read_value), int'(read_value_o));
          report_field("entry_count", int'(want.entry_count), int'(entry_count_o));
          checked_count++;
          status_tally[want.status]++;
          if (want.entry_count > peak_count) peak_count = want.entry_count;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding.",
               cycle_count, pending_results.size());
      $display("indexed_list_engine_test: FAIL");
      $finish;
    end
  end

  // Result side: segments of steady, random, patterned and fully held-off
  // ready. Every sixth segment is a long hold-off so the pipeline backs up.
  initial begin : result_sink
    sink_mode_e   mode;
    int unsigned  seg;
    int unsigned  span;
    int unsigned  stride;
    int unsigned  k;
    wait (rst_ni);
    seg = 0;
    forever begin
      if (seg % 6 == 1) mode = SINK_HOLD;
      else mode = sink_mode_e'($urandom_range(SINK_STEADY, SINK_PATTERN));
      span = (mode == SINK_HOLD) ? $urandom_range(40, 80) : $urandom_range(20, 120);
      stride = $urandom_range(2, 4);
      for (k = 0; k < span; k++) begin
        @(posedge clk_i);
        case (mode)
          SINK_STEADY:  out_ready_i <= 1'b1;
          SINK_RANDOM:  out_ready_i <= 1'($urandom_range(0, 1));
          SINK_PATTERN: out_ready_i <= (k % stride == 0);
          default:      out_ready_i <= 1'b0;
        endcase
      end
      seg++;
    end
  end

  initial begin : request_source
    stim_row_t        row;
    logic [2:0]       op;
    logic [6:0]       pos;
    ile_pkg::value_t  val;
    tide_e            tide;
    int unsigned      roll;
    int unsigned      burst;
    int unsigned      ins_pct;
    int unsigned      del_pct;
    int unsigned      items_sent;
    int unsigned      next_pause;
    int unsigned      tide_hold;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      offer(row.op, row.pos, row.val, row.typed, row.want);
    end
    idle(1);

    // The list count used for steering may lag one transaction behind; it is
    // only a hint, the checker predicts from what was actually accepted.
    tide = TIDE_FILL;
    tide_hold = 0;
    items_sent = 0;
    next_pause = PAUSE_EVERY;
    while (items_sent < RANDOM_ITEMS) begin
      burst = $urandom_range(1, 40);
      repeat (burst) begin
        ins_pct = (tide == TIDE_FILL) ? 70 : (tide == TIDE_DRAIN) ? 15 : 40;
        del_pct = (tide == TIDE_FILL) ? 15 : (tide == TIDE_DRAIN) ? 65 : 35;
        if ($urandom_range(0, 99) < 4) begin
          op = 3'($urandom_range(OP_RSVD5, OP_RSVD7));
        end else begin
          roll = $urandom_range(0, 99);
          if (roll < ins_pct) begin
            op = 3'($urandom_range(ile_pkg::OP_INS_FRONT, ile_pkg::OP_INS_AT));
          end else if (roll < ins_pct + del_pct) begin
            op = ile_pkg::OP_DELETE;
          end else begin
            op = ile_pkg::OP_READ;
          end
        end

        roll = $urandom_range(0, 9);
        if (roll == 0) pos = 7'($urandom);
        else if (roll == 1) pos = 7'(list_count);
        else if (op == ile_pkg::OP_INS_AT) pos = 7'($urandom_range(0, list_count));
        else if (list_count == 0) pos = '0;
        else pos = 7'($urandom_range(0, list_count - 1));

        case ($urandom_range(0, 12))
          0:       val = 32'sh8000_0000;
          1:       val = 32'sh7FFF_FFFF;
          2:       val = 32'sd0;
          3:       val = 32'shFFFF_FFFF;
          default: val = $urandom;
        endcase

        offer(op, pos, val, 1'b0, '0);
        if (op <= ile_pkg::OP_DELETE) items_sent++;

        // Fill to the top and linger there, drain to empty, then churn and start over.
        case (tide)
          TIDE_FILL: begin
            if (list_count == LIST_DEPTH) tide_hold++;
            if (tide_hold > 15) begin
              tide = TIDE_DRAIN;
              tide_hold = 0;
            end
          end
          TIDE_DRAIN: begin
            if (list_count == 0) tide_hold++;
            if (tide_hold > 5) begin
              tide = TIDE_CHURN;
              tide_hold = 0;
            end
          end
          default: begin
            tide_hold++;
            if (tide_hold > 80) begin
              tide = TIDE_FILL;
              tide_hold = 0;
            end
          end
        endcase
      end

      if (items_sent >= next_pause) begin
        idle(1);
        while (pending_results.size() != 0) @(posedge clk_i);
        idle(PIPE_LATENCY);
        next_pause += PAUSE_EVERY;
      end else if ($urandom_range(0, 9) < 7) begin
        idle($urandom_range(1, 8));
      end
    end

    idle(1);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Checked %0d result transactions: %0d done, %0d out of range, %0d full.",
             checked_count, status_tally[ile_pkg::ST_DONE], status_tally[ile_pkg::ST_OOR],
             status_tally[ile_pkg::ST_FULL]);
    $display("Deepest list seen: %0d of %0d entries, %0d cycles.", peak_count,
             LIST_DEPTH, cycle_count);
    if (mismatch_count == 0) begin
      $display("indexed_list_engine_test: PASS");
    end else begin
      $display("indexed_list_engine_test: FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+src
src/ile_pkg.sv
src/ile_cell.sv
src/indexed_list_engine.sv
tb/indexed_list_engine_test.sv
